>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the averager RTL
// Clocked property checks that report through $error.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is high.
`define ASSERT_SYNC(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Once a flag is set it stays set until reset.
`define ASSERT_HOLD(name, clk, rst, sig, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (sig) |=> (sig)) else $error(msg);

`endif

>>> design/madad_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// madad_pkg
// Types, constants and helpers shared by the ADC decimator modules.
// ---------------------------------------------------------------------------
package madad_pkg;

   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 16;
   localparam int LIMIT_W    = 16;
   localparam int CSR_DATA_W = 16;
   localparam int NUM_LANES  = 4;

   localparam int LANE_SPEED   = 0;
   localparam int LANE_SUPPLY  = 1;
   localparam int LANE_CURRENT = 2;
   localparam int LANE_KEY     = 3;

   localparam int DEF_BLOCK_SAMPLES = 8;
   localparam int DEF_SUM_SHIFT     = 3;
   localparam int DEF_SAMPLE_BITS   = 12;

   localparam int SPEED_SHIFT         = 3;
   localparam int KEY_SHIFT           = 3;
   localparam int SUPPLY_EXTRA_SHIFT  = 4;
   localparam int CURRENT_EXTRA_SHIFT = 2;
   localparam int BASELINE_LOW        = 100;

   localparam logic [SAMPLE_W-1:0] RST_DEAD_ZONE   = SAMPLE_W'(120);
   localparam logic [SAMPLE_W-1:0] RST_SUPPLY_BAND = SAMPLE_W'(6);
   localparam logic [LIMIT_W-1:0]  RST_MARGIN      = LIMIT_W'(200);

   typedef enum logic [1:0] {
      CSR_SPEED_DEAD_ZONE = 2'd0,
      CSR_SUPPLY_BAND     = 2'd1,
      CSR_CURRENT_MARGIN  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] speed_dead_zone;
      logic [SAMPLE_W-1:0] supply_band;
      logic [LIMIT_W-1:0]  current_margin;
   } cfg_type;

   typedef struct packed {
      logic close;
      logic window;
   } stage_ctrl_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] speed_value;
      logic [SAMPLE_W-1:0] supply_value;
      logic [SAMPLE_W-1:0] current_value;
      logic [SAMPLE_W-1:0] key_value;
      logic [SAMPLE_W-1:0] current_baseline;
      logic [LIMIT_W-1:0]  current_limit;
      logic                baseline_error;
      logic                block_done;
   } result_type;

   // Clamp a scaled sum to the 12-bit result range.
   function automatic logic [SAMPLE_W-1:0] sat_sample(input logic [SUM_W-1:0] v);
      if (|v[SUM_W-1:SAMPLE_W]) begin
         return '1;
      end
      return v[SAMPLE_W-1:0];
   endfunction

endpackage

>>> design/madad_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// madad_req_if / madad_rsp_if
// Valid/ready channels for sample sets and averaged results.
// ---------------------------------------------------------------------------
interface madad_req_if;
   import madad_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] speed_sample;
   logic [SAMPLE_W-1:0] supply_sample;
   logic [SAMPLE_W-1:0] current_sample;
   logic [SAMPLE_W-1:0] key_sample;
   logic                startup_window;

   modport source (
      output valid, speed_sample, supply_sample, current_sample, key_sample,
             startup_window,
      input  ready
   );
   modport sink (
      input  valid, speed_sample, supply_sample, current_sample, key_sample,
             startup_window,
      output ready
   );
endinterface

interface madad_rsp_if;
   import madad_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] speed_value;
   logic [SAMPLE_W-1:0] supply_value;
   logic [SAMPLE_W-1:0] current_value;
   logic [SAMPLE_W-1:0] key_value;
   logic [SAMPLE_W-1:0] current_baseline;
   logic [LIMIT_W-1:0]  current_limit;
   logic                baseline_error;
   logic                block_done;

   modport source (
      output valid, speed_value, supply_value, current_value, key_value,
             current_baseline, current_limit, baseline_error, block_done,
      input  ready
   );
   modport sink (
      input  valid, speed_value, supply_value, current_value, key_value,
             current_baseline, current_limit, baseline_error, block_done,
      output ready
   );
endinterface

>>> design/madad_lane.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// madad_lane
// One channel accumulator: sums masked samples and dumps the block total.
// ---------------------------------------------------------------------------
module madad_lane #(
   parameter int SAMPLE_BITS = madad_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          close,
   input  logic [madad_pkg::SAMPLE_W-1:0] sample,
   output logic [madad_pkg::SUM_W-1:0]    dump
);
   import madad_pkg::*;

   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;
   logic [SUM_W-1:0] dump_ff;
   logic [SUM_W-1:0] total;

   // Bits above SAMPLE_BITS are dropped; the sum wraps at 16 bits.
   assign total  = sum_ff + SUM_W'(sample[SAMPLE_BITS-1:0]);
   assign sum_in = close ? '0 : total;
   assign dump   = dump_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (load) begin
         sum_ff <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         dump_ff <= total;
      end
   end

endmodule

>>> design/madad_merge.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// madad_merge
// Scales the lane totals into held averages and tracks baseline and limit.
// ---------------------------------------------------------------------------
module madad_merge #(
   parameter int SUM_SHIFT = madad_pkg::DEF_SUM_SHIFT
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             load,
   input  madad_pkg::stage_ctrl_type                        ctrl,
   input  logic [madad_pkg::NUM_LANES-1:0][madad_pkg::SUM_W-1:0] sums,
   input  madad_pkg::cfg_type                               cfg,
   output madad_pkg::result_type                            result
);
   import madad_pkg::*;

   result_type          result_ff;
   result_type          result_in;
   logic [SAMPLE_W-1:0] speed_avg;
   logic [SAMPLE_W-1:0] supply_avg;
   logic [SAMPLE_W-1:0] current_avg;
   logic [SAMPLE_W-1:0] key_avg;
   logic [SAMPLE_W:0]   supply_hi;
   logic [SAMPLE_W:0]   supply_lo;
   logic [LIMIT_W:0]    limit_sum;

   assign speed_avg   = sat_sample(sums[LANE_SPEED] >> SPEED_SHIFT);
   assign supply_avg  = sat_sample(sums[LANE_SUPPLY] >> (SUM_SHIFT + SUPPLY_EXTRA_SHIFT));
   assign current_avg = sat_sample(sums[LANE_CURRENT] >> (SUM_SHIFT + CURRENT_EXTRA_SHIFT));
   assign key_avg     = sat_sample(sums[LANE_KEY] >> KEY_SHIFT);

   // Both sides of the hysteresis band, one bit wider so nothing wraps.
   assign supply_hi = {1'b0, result_ff.supply_value} + {1'b0, cfg.supply_band};
   assign supply_lo = {1'b0, supply_avg} + {1'b0, cfg.supply_band};

   always_comb begin
      result_in            = result_ff;
      result_in.block_done = ctrl.close;
      limit_sum            = '0;
      if (ctrl.close) begin
         result_in.speed_value   = (speed_avg > cfg.speed_dead_zone) ? speed_avg : '0;
         if (({1'b0, supply_avg} > supply_hi) || ({1'b0, result_ff.supply_value} > supply_lo)) begin
            result_in.supply_value = supply_avg;
         end
         result_in.current_value = current_avg;
         result_in.key_value     = key_avg;
      end
      if (ctrl.window) begin
         // Baseline follows the freshly updated current average.
         limit_sum = (LIMIT_W + 1)'(result_in.current_value) + {1'b0, cfg.current_margin};
         result_in.current_baseline = result_in.current_value;
         result_in.current_limit    = limit_sum[LIMIT_W] ? '1 : limit_sum[LIMIT_W-1:0];
      end else if ((result_ff.current_baseline != '0) &&
                   (result_ff.current_baseline < SAMPLE_W'(BASELINE_LOW))) begin
         result_in.baseline_error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
      end else if (load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

>>> design/multi_channel_adc_decimator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// multi_channel_adc_decimator
// Four-channel accumulate-and-dump averager for ADC sample sets.
// ---------------------------------------------------------------------------
//
//   Port group | Direction | Carries
//   -----------+-----------+-------------------------------------------------
//   req_bus    | in        | one sample set per transfer (four channels + window)
//   rsp_bus    | out       | held averages, baseline, limit, error, block done
//   csr_*      | in        | register writes: dead zone, supply band, margin
//
// The block accepts one sample set every cycle while the output is not stalled.
// A result is presented after its transfer: the transfer edge sums the samples
// into the lanes, and the merge stage, once the output can advance, scales
// and filters them into the output register.
// Reset is synchronous and active high; it clears the sums, the sample count,
// all held values and the error flag, and loads register defaults.
// A stalled output holds its result; the lane stage keeps accepting while it
// has room, so one further set can enter behind a waiting result.
//
module multi_channel_adc_decimator #(
   parameter int BLOCK_SAMPLES = madad_pkg::DEF_BLOCK_SAMPLES,
   parameter int SUM_SHIFT     = madad_pkg::DEF_SUM_SHIFT,
   parameter int SAMPLE_BITS   = madad_pkg::DEF_SAMPLE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   madad_req_if.sink                         req_bus,
   madad_rsp_if.source                       rsp_bus,
   input  logic                              csr_we,
   input  madad_pkg::csr_index_type          csr_index,
   input  logic [madad_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import madad_pkg::*;

`include "assert_macros.svh"

   // The count must be able to reach BLOCK_SAMPLES - 1.
   localparam int CNT_W = $clog2(BLOCK_SAMPLES);

   // Configuration registers.
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Lane stage control.
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             s1_valid_ff;
   logic             s1_valid_in;
   stage_ctrl_type   s1_ctrl_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;

   logic             advance;
   logic             req_ready;
   logic             req_xfer;
   logic             block_close;
   logic             merge_load;

   logic [NUM_LANES-1:0][SAMPLE_W-1:0] lane_sample;
   logic [NUM_LANES-1:0][SUM_W-1:0]    lane_sum;
   result_type                         result;

   // -------------------------------------------------------------------
   // Handshake. The output register advances when empty or when its
   // transfer completes; the lane stage takes a new set whenever it is
   // empty or its contents move on to the output in the same cycle.
   // -------------------------------------------------------------------
   assign advance     = !rsp_valid_ff || rsp_bus.ready;
   assign req_ready   = !s1_valid_ff || advance;
   assign req_xfer    = req_bus.valid && req_ready;
   assign merge_load  = s1_valid_ff && advance;
   assign req_bus.ready = req_ready;

   // The item that brings the count to BLOCK_SAMPLES closes the block.
   assign block_close = (count_ff == CNT_W'(BLOCK_SAMPLES - 1));
   assign count_in    = block_close ? '0 : count_ff + CNT_W'(1);

   assign s1_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_ctrl_ff.close  <= block_close;
         s1_ctrl_ff.window <= req_bus.startup_window;
      end
   end

   // -------------------------------------------------------------------
   // Configuration writes. Indexes beyond the register list are dropped.
   // -------------------------------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      case (csr_index)
         CSR_SPEED_DEAD_ZONE: begin
            cfg_in.speed_dead_zone = csr_wdata[SAMPLE_W-1:0];
         end
         CSR_SUPPLY_BAND: begin
            cfg_in.supply_band = csr_wdata[SAMPLE_W-1:0];
         end
         CSR_CURRENT_MARGIN: begin
            cfg_in.current_margin = csr_wdata[LIMIT_W-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_dead_zone <= RST_DEAD_ZONE;
         cfg_ff.supply_band     <= RST_SUPPLY_BAND;
         cfg_ff.current_margin  <= RST_MARGIN;
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   // -------------------------------------------------------------------
   // Four accumulator lanes, one per ADC channel, fed from one transfer.
   // -------------------------------------------------------------------
   assign lane_sample[LANE_SPEED]   = req_bus.speed_sample;
   assign lane_sample[LANE_SUPPLY]  = req_bus.supply_sample;
   assign lane_sample[LANE_CURRENT] = req_bus.current_sample;
   assign lane_sample[LANE_KEY]     = req_bus.key_sample;

   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      madad_lane #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
         .clock  (clock),
         .reset  (reset),
         .load   (req_xfer),
         .close  (block_close),
         .sample (lane_sample[g]),
         .dump   (lane_sum[g])
      );
   end

   // -------------------------------------------------------------------
   // Merge stage: its registers are the output register of rsp_bus.
   // -------------------------------------------------------------------
   madad_merge #(
      .SUM_SHIFT (SUM_SHIFT)
   ) u_merge (
      .clock  (clock),
      .reset  (reset),
      .load   (merge_load),
      .ctrl   (s1_ctrl_ff),
      .sums   (lane_sum),
      .cfg    (cfg_ff),
      .result (result)
   );

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.speed_value      = result.speed_value;
   assign rsp_bus.supply_value     = result.supply_value;
   assign rsp_bus.current_value    = result.current_value;
   assign rsp_bus.key_value        = result.key_value;
   assign rsp_bus.current_baseline = result.current_baseline;
   assign rsp_bus.current_limit    = result.current_limit;
   assign rsp_bus.baseline_error   = result.baseline_error;
   assign rsp_bus.block_done       = result.block_done;

   // -------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------
   `ASSERT_SYNC(a_count_restart, clock, reset, (req_xfer && block_close) |=> (count_ff == '0), "sample count did not restart after block close")
   `ASSERT_SYNC(a_done_tracks_close, clock, reset, merge_load |=> (result.block_done == $past(s1_ctrl_ff.close)), "block_done does not match the closing item")
   `ASSERT_SYNC(a_limit_floor, clock, reset, result.current_limit >= LIMIT_W'(result.current_baseline), "current limit fell below baseline")
   `ASSERT_HOLD(a_error_sticky, clock, reset, result.baseline_error, "baseline error flag cleared without reset")

endmodule
